// ===== hw/rtl/integer_to_ascii_text_unit_assert.svh =====
// assertion macros for the integer to ascii text unit
`ifndef INTEGER_TO_ASCII_TEXT_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_TEXT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ITAU_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("itau same-cycle check failed");

// next-cycle implication, checked out of reset
`define ITAU_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("itau next-cycle check failed");

`endif

// ===== hw/rtl/itau_pkg.sv =====
// shared types, constants and helpers for the integer to ascii text unit
package itau_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // reciprocal of ten scaled by 2^35, exact for every 32-bit dividend
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_ZERO,
        S_X,
        S_SIGN,
        S_DIGITS
    } state_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ZERO,
        EMIT_X,
        EMIT_MINUS,
        EMIT_DIGIT
    } emit_t;

    typedef struct packed {
        logic  load;
        logic  split;
        emit_t emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic split_done;
        logic is_hex;
        logic is_neg;
        logic last_digit;
    } dp_status_t;

    function automatic logic [7:0] glyph(input logic [3:0] d);
        if (d < 4'd10)
        begin
            glyph = CHAR_ZERO + {4'd0, d};
        end
        else
        begin
            glyph = 8'h57 + {4'd0, d};
        end
    endfunction

endpackage

// ===== hw/rtl/itau_ctrl.sv =====
// sequencing state machine: load, digit split, prefix and digit emission
module itau_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             opcode,
    input  itau_pkg::dp_status_t   status,
    output itau_pkg::ctrl_cmd_t    cmd,
    output logic                   busy
);
    import itau_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && opcode != OP_NONE)
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                if (status.split_done)
                begin
                    if (status.is_hex)
                    begin
                        state_next = S_ZERO;
                    end
                    else if (status.is_neg)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        state_next = S_DIGITS;
                    end
                end
            end
            S_ZERO:   state_next = S_X;
            S_X:      state_next = S_DIGITS;
            S_SIGN:   state_next = S_DIGITS;
            S_DIGITS:
            begin
                if (status.last_digit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load  = 1'b0;
        cmd.split = 1'b0;
        cmd.emit  = EMIT_NONE;
        busy      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start && opcode != OP_NONE;
            end
            S_SPLIT:  cmd.split = 1'b1;
            S_ZERO:   cmd.emit  = EMIT_ZERO;
            S_X:      cmd.emit  = EMIT_X;
            S_SIGN:   cmd.emit  = EMIT_MINUS;
            S_DIGITS: cmd.emit  = EMIT_DIGIT;
            default:  cmd.emit  = EMIT_NONE;
        endcase
    end

endmodule

// ===== hw/rtl/itau_dpath.sv =====
// datapath: value register, digit split, digit store and output register
module itau_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             opcode,
    input  logic [63:0]            number,
    input  itau_pkg::ctrl_cmd_t    cmd,
    output itau_pkg::dp_status_t   status,
    output logic [7:0]             out_char,
    output logic                   last,
    output logic                   strobe
);
    import itau_pkg::*;

    logic [63:0]      rem_reg;
    logic [63:0]      rem_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             hex_reg;
    logic             neg_reg;
    logic [3:0]       digit_store [MAX_DIGITS];
    logic [7:0]       char_reg;
    logic [7:0]       char_next;
    logic             last_reg;
    logic             last_next;
    logic             strobe_reg;

    logic [31:0]      low_word;
    logic [31:0]      load_word;
    logic [63:0]      prod;
    logic [28:0]      quot;
    logic [31:0]      quot_ten;
    logic [31:0]      dec_rem;
    logic [3:0]       digit;
    logic [63:0]      split_rem;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] cnt_dec;
    logic [IDX_W-1:0] rd_idx;

    // divide by ten through the reciprocal, remainder by shift and add
    assign prod      = {32'd0, rem_reg[31:0]} * {32'd0, RECIP_TEN};
    assign quot      = prod[63:35];
    assign quot_ten  = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign dec_rem   = rem_reg[31:0] - quot_ten;
    assign digit     = hex_reg ? rem_reg[3:0] : dec_rem[3:0];
    assign split_rem = hex_reg ? {4'd0, rem_reg[63:4]} : {35'd0, quot};
    assign cnt_inc   = count_reg + CNT_W'(1);
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign rd_idx    = cnt_dec[IDX_W-1:0];

    assign low_word  = number[31:0];
    assign load_word = (opcode == OP_SDEC && low_word[31]) ? (~low_word + 32'd1) : low_word;

    assign status.split_done = (split_rem == 64'd0) || (cnt_inc == CNT_W'(MAX_DIGITS));
    assign status.is_hex     = hex_reg;
    assign status.is_neg     = neg_reg;
    assign status.last_digit = (count_reg == CNT_W'(1));

    always_comb
    begin
        rem_next   = rem_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            rem_next   = (opcode == OP_HEX) ? number : {32'd0, load_word};
            count_next = '0;
        end
        else if (cmd.split)
        begin
            rem_next   = split_rem;
            count_next = cnt_inc;
        end
        else if (cmd.emit == EMIT_DIGIT)
        begin
            count_next = cnt_dec;
        end
    end

    always_comb
    begin
        char_next = CHAR_ZERO;
        last_next = 1'b0;
        case (cmd.emit)
            EMIT_ZERO:  char_next = CHAR_ZERO;
            EMIT_X:     char_next = CHAR_X;
            EMIT_MINUS: char_next = CHAR_MINUS;
            EMIT_DIGIT:
            begin
                char_next = glyph(digit_store[rd_idx]);
                last_next = (count_reg == CNT_W'(1));
            end
            default:    char_next = CHAR_ZERO;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            count_reg  <= '0;
            hex_reg    <= 1'b0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            rem_reg    <= rem_next;
            count_reg  <= count_next;
            strobe_reg <= (cmd.emit != EMIT_NONE);
            last_reg   <= last_next;
            if (cmd.load)
            begin
                hex_reg <= (opcode == OP_HEX);
                neg_reg <= (opcode == OP_SDEC) && low_word[31];
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        if (cmd.split)
        begin
            digit_store[count_reg[IDX_W-1:0]] <= digit;
        end
    end

    assign out_char = char_reg;
    assign last     = last_reg;
    assign strobe   = strobe_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_text_unit.sv =====
// integer to ascii text unit: top level joining controller and datapath
// order: the value is loaded, then split one digit at a time (1..10 decimal, 1..16 hex),
// then sent out one character per cycle; each character is registered and leaves
// in the cycle after its emit; a new item is accepted only back in idle, with busy low
// asynchronous active-low reset returns to idle with no strobe; results cannot be stalled
module integer_to_ascii_text_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [63:0] number,
    output logic [7:0]  out_char,
    output logic        last,
    output logic        strobe
);
    import itau_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    itau_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    itau_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .opcode   (opcode),
        .number   (number),
        .cmd      (cmd),
        .status   (status),
        .out_char (out_char),
        .last     (last),
        .strobe   (strobe)
    );

`include "integer_to_ascii_text_unit_assert.svh"

    // an accepted item with a real opcode keeps the unit busy
    `ITAU_ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load, busy)
    // the final character of a run is followed by a quiet cycle
    `ITAU_ASSERT_NEXT(a_last_quiet, clk, rst_n, strobe && last, !strobe)
    // no character leaves while digits are still being split
    `ITAU_ASSERT_SAME(a_split_quiet, clk, rst_n, cmd.split, !strobe)
    // digit emission never starts with an empty store
    `ITAU_ASSERT_SAME(a_emit_nonempty, clk, rst_n, cmd.emit == EMIT_DIGIT, u_dpath.count_reg != '0)

endmodule

// ===== test/integer_to_ascii_text_unit_tb.sv =====
// testbench for the integer to ascii text unit: directed and random items against a predictor
`timescale 1ns / 100ps

module integer_to_ascii_text_unit_tb;

    import itau_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  opcode = OP_SDEC;
    logic [63:0] number = 64'd0;
    logic        busy;
    logic [7:0]  out_char;
    logic        last;
    logic        strobe;

    text_char_t expected_text[$];
    int         mismatch_count = 0;
    int         chars_checked = 0;
    int         items_by_op[4] = '{0, 0, 0, 0};
    int         idle_pct = 0;
    int         stall_cycles = 0;

    integer_to_ascii_text_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .opcode   (opcode),
        .number   (number),
        .out_char (out_char),
        .last     (last),
        .strobe   (strobe)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // builds the characters one item should produce and queues them
    function automatic void predict_text(input logic [1:0] op, input logic [63:0] value);
        logic [63:0] rest;
        logic [3:0]  digits [MAX_DIGITS];
        logic [63:0] radix;
        logic        negative;
        text_char_t  tc;
        int          count;
        int          first;
        rest = value;
        negative = 1'b0;
        count = 0;
        first = expected_text.size();
        if (op == OP_NONE)
        begin
            return;
        end
        if (op == OP_HEX)
        begin
            radix = 64'd16;
        end
        else
        begin
            radix = 64'd10;
            rest = {32'd0, value[31:0]};
            if (op == OP_SDEC && value[31])
            begin
                negative = 1'b1;
                rest = {32'd0, -value[31:0]};
            end
        end
        do
        begin
            digits[count] = 4'(rest % radix);
            rest = rest / radix;
            count++;
        end
        while (rest != 64'd0 && count < MAX_DIGITS);
        tc.last = 1'b0;
        if (op == OP_HEX)
        begin
            tc.ch = CHAR_ZERO;
            expected_text.push_back(tc);
            tc.ch = CHAR_X;
            expected_text.push_back(tc);
        end
        else if (negative)
        begin
            tc.ch = CHAR_MINUS;
            expected_text.push_back(tc);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            tc.ch = (digits[i] < 4'd10) ? CHAR_ZERO + 8'(digits[i])
                                        : 8'h61 + 8'(digits[i]) - 8'd10;
            expected_text.push_back(tc);
        end
        expected_text[expected_text.size() - 1].last = 1'b1;
        if (first >= expected_text.size())
        begin
            $error("predictor produced no text");
        end
    endfunction

    // one transfer in; start stays high when the next item follows at once
    task automatic send_item(input logic [1:0] op, input logic [63:0] value);
        start <= 1'b1;
        opcode <= op;
        number <= value;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        predict_text(op, value);
        items_by_op[op]++;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_reset();
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_directed();
        idle_pct = 0;
        send_item(OP_SDEC, 64'd0);
        send_item(OP_SDEC, 64'd1);
        send_item(OP_SDEC, 64'h0000_0000_FFFF_FFFF);
        // most negative 32-bit value must print all ten digits
        send_item(OP_SDEC, 64'h0000_0000_8000_0000);
        send_item(OP_SDEC, 64'h0000_0000_7FFF_FFFF);
        send_item(OP_SDEC, 64'hFFFF_FFFF_0000_0005);
        send_item(OP_SDEC, 64'hFFFF_FFFF_FFFF_FFF6);
        send_item(OP_UDEC, 64'd0);
        send_item(OP_UDEC, 64'h0000_0000_FFFF_FFFF);
        send_item(OP_UDEC, 64'h0000_0000_8000_0000);
        send_item(OP_UDEC, 64'hFFFF_FFFF_3B9A_CA00);
        send_item(OP_UDEC, 64'd9);
        send_item(OP_HEX, 64'd0);
        send_item(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_HEX, 64'h8000_0000_0000_0000);
        send_item(OP_HEX, 64'h0123_4567_89AB_CDEF);
        send_item(OP_HEX, 64'hF);
        send_item(OP_HEX, 64'h0000_0000_8000_0000);
        // unused opcode: no text, state untouched
        send_item(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_NONE, 64'd0);
        send_item(OP_SDEC, 64'h0000_0000_FFFF_FF85);
        send_item(OP_NONE, 64'h1234);
        send_item(OP_UDEC, 64'd10);
        wait_for_drain();
    endtask

    task automatic test_random(input int item_total, input int pct, input bit mid_pause);
        int          sent;
        int          pick;
        logic [1:0]  op;
        logic [63:0] value;
        sent = 0;
        idle_pct = pct;
        while (sent < item_total)
        begin
            pick = $urandom_range(0, 19);
            op = (pick == 0) ? OP_NONE : 2'(pick % 3);
            value = {$urandom, $urandom} >> $urandom_range(0, 63);
            if ($urandom_range(0, 7) == 0)
            begin
                value[31:0] = -32'($urandom_range(1, 1000));
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                value = {$urandom, $urandom};
            end
            send_item(op, value);
            if (op != OP_NONE)
            begin
                sent++;
            end
            if (mid_pause && sent == item_total / 2)
            begin
                wait_for_drain();
            end
        end
        start <= 1'b0;
    endtask

    // result checker: every strobed character against the oldest expectation
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && strobe)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected transfer: out_char %h last %b", out_char, last);
                mismatch_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                chars_checked++;
                if (out_char !== want.ch)
                begin
                    $error("out_char: expected %h, got %h", want.ch, out_char);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        test_reset();
        test_directed();
        test_random(28, 10, 1'b0);
        test_random(28, 79, 1'b1);
        test_random(28, 0, 1'b0);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            $error("%0d characters never arrived", expected_text.size());
            mismatch_count++;
        end
        $display("items: %0d signed, %0d unsigned, %0d hex, %0d ignored opcode",
                 items_by_op[OP_SDEC], items_by_op[OP_UDEC], items_by_op[OP_HEX],
                 items_by_op[OP_NONE]);
        $display("%0d characters checked, %0d mismatches", chars_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
